[rtl/ins_sort_pkg.sv]
`default_nettype none

package ins_sort_pkg;

    // Store depth and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_count;

    // Controller to datapath
    typedef struct packed {
        logic insert;   // write the incoming value into the sorted store
        logic set_ovf;  // incoming value found the store full
        logic load_out; // move the head entry into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;     // store holds CAPACITY entries
        logic one_left; // exactly one entry remains
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/ins_sort_datapath.sv]
`default_nettype none

module ins_sort_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ins_sort_pkg::t_dp_cmd i_cmd,
    input  wire ins_sort_pkg::t_word   i_value,
    output ins_sort_pkg::t_dp_sts      o_sts,
    output ins_sort_pkg::t_word        o_sorted_value,
    output logic                       o_end_of_batch,
    output logic                       o_dropped
);
    import ins_sort_pkg::*;

    t_word  r_store [CAPACITY];
    t_word  n_store [CAPACITY];
    logic   [CAPACITY-1:0] w_gt;
    t_count r_count;
    logic   r_ovf;
    t_word  r_out_value;
    logic   r_out_end;
    logic   r_out_drop;

    // Entry i moves up when the new value goes below it, or when it is free
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_gt[i] = (t_count'(i) >= r_count) || (i_value < r_store[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.load_out) begin
                n_store[i] = (i < CAPACITY - 1) ? r_store[(i + 1) % CAPACITY] : r_store[i];
            end else if (i_cmd.insert && w_gt[i]) begin
                if (i > 0 && w_gt[(i + CAPACITY - 1) % CAPACITY]) begin
                    n_store[i] = r_store[(i + CAPACITY - 1) % CAPACITY];
                end else begin
                    n_store[i] = i_value;
                end
            end else begin
                n_store[i] = r_store[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_count <= r_count + t_count'(1);
            end else if (i_cmd.load_out) begin
                r_count <= r_count - t_count'(1);
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end else if (i_cmd.load_out && o_sts.one_left) begin
                r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= r_store[0];
            r_out_end   <= o_sts.one_left;
            r_out_drop  <= r_ovf;
        end
    end

    assign o_sts.full     = (r_count == t_count'(CAPACITY));
    assign o_sts.one_left = (r_count == t_count'(1));
    assign o_sorted_value = r_out_value;
    assign o_end_of_batch = r_out_end;
    assign o_dropped      = r_out_drop;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> r_count != '0)
        else $error("pop from empty store");

    a_last_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && o_sts.one_left |=> r_count == '0 && !r_ovf)
        else $error("batch state not cleared after final result");
`endif

endmodule

`default_nettype wire

[rtl/ins_sort_ctrl.sv]
`default_nettype none

module ins_sort_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_last,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire ins_sort_pkg::t_dp_sts  i_sts,
    output ins_sort_pkg::t_dp_cmd       o_cmd
);
    import ins_sort_pkg::*;

    localparam logic S_FILL  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_in_acc;
    logic w_slot_free;

    assign o_in_ready  = (r_state == S_FILL);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.insert   = w_in_acc && !i_sts.full;
        o_cmd.set_ovf  = w_in_acc && i_sts.full;
        o_cmd.load_out = (r_state == S_DRAIN) && w_slot_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL: begin
                if (w_in_acc && i_in_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (o_cmd.load_out && i_sts.one_left) begin
                    n_state = S_FILL;
                end
            end
            default: n_state = S_FILL;
        endcase
    end

    always_comb begin
        priority if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_last_enters_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_last |=> r_state == S_DRAIN)
        else $error("last request did not start drain");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

    a_no_insert_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> !o_cmd.insert && !o_cmd.set_ovf)
        else $error("request taken while draining");
`endif

endmodule

`default_nettype wire

[rtl/insertion_sorter_core.sv]
`default_nettype none

// Batch insertion sorter.
// Input channel (s_axis): one signed 32-bit value per request; tlast marks
// the final value of a batch. Each value that finds room is inserted into a
// sorted register array of CAPACITY entries in the cycle it is accepted, so
// values stream in at one per cycle while filling. Ties keep arrival order.
// Output channel (m_axis): once the tlast request is taken, the batch leaves
// in ascending order, one result per cycle while m_axis_tready is high.
// tlast flags the final result, tuser is set on every result of a batch in
// which values were dropped because the store was already full.
// The tlast request moves the core to draining, which loads the head entry
// into the output register to present the first result. s_axis_tready is
// low while draining; a new batch may start the cycle after the last result
// is loaded, while that result still waits in the output register.
// Stall: a low m_axis_tready holds the output register and pauses the drain.
// Reset: empties the store, clears the overflow flag and the output valid.
module insertion_sorter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] value
    input  wire logic        s_axis_tlast,  // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // [31:0] sorted_value
    output logic             m_axis_tlast,  // end_of_batch
    output logic             m_axis_tuser   // [0] dropped
);
    import ins_sort_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_word   w_sorted_value;

    // Sequencing: fill until the tlast request, then drain one entry per free slot
    ins_sort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Sorted register array, entry count, overflow flag and output register
    ins_sort_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (t_word'(s_axis_tdata)),
        .o_sts          (w_sts),
        .o_sorted_value (w_sorted_value),
        .o_end_of_batch (m_axis_tlast),
        .o_dropped      (m_axis_tuser)
    );

    assign m_axis_tdata = 32'(w_sorted_value);

endmodule

`default_nettype wire
